// File: rtl/core/typed_fifo_with_unique_push_and_purge_defines.svh
// Assertion macros for the typed FIFO.
`ifndef TYPED_FIFO_WITH_UNIQUE_PUSH_AND_PURGE_DEFINES_SVH
`define TYPED_FIFO_WITH_UNIQUE_PUSH_AND_PURGE_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define TF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/tfq_pkg.sv
// Package: opcodes, states and defaults for the typed FIFO.
package tfq_pkg;
    localparam int DefDepth       = 16;
    localparam int DefTypeBits    = 8;
    localparam int DefPayloadBits = 32;
    localparam int OutTypeBits    = 8;
    localparam int OutPayloadBits = 32;
    localparam int CountBits      = 5;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_DROP   = 3'd2,
        OP_UPUSH  = 3'd3,
        OP_PURGE  = 3'd4,
        OP_FLUSH  = 3'd5,
        OP_RSVD6  = 3'd6,
        OP_RSVD7  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POPRD,
        ST_SCAN,
        ST_RESULT
    } state_t;
endpackage

// File: rtl/core/typed_fifo_with_unique_push_and_purge.sv
// Typed FIFO with push, pop, drop, unique push, purge and flush.
// Push, drop, flush, invalid ops and unique push when full give a result word in the
// cycle after accept; pop first passes ST_POPRD for the registered memory read; unique
// push and purge scan held entries, one per cycle through the single read port.
// One request in flight; the next word is accepted the cycle after the result is taken.
// Reset (aresetn low, synchronous): empty queue, capacity 16; store contents undefined.
module typed_fifo_with_unique_push_and_purge #(
    parameter int DEPTH        = tfq_pkg::DefDepth,
    parameter int TYPE_BITS    = tfq_pkg::DefTypeBits,
    parameter int PAYLOAD_BITS = tfq_pkg::DefPayloadBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,     // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] op, [TYPE_BITS+2:3] entry type, then entry payload; zero filled to bytes
    input  logic [((3+TYPE_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] ok, [8:1] out_type, [40:9] out_payload, [45:41] fill_count,
    // [46] is_empty, [47] is_full
    output logic [47:0] m_tdata
);
    import tfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = TYPE_BITS + PAYLOAD_BITS;

    // entry store: one write port, one registered read port
    logic [EW-1:0] mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd, mem_rd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd <= mem[mem_ra];
    end

    state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [CW-1:0] cnt_reg, cnt_next, left_reg, left_next, kept_reg, kept_next;
    logic [4:0]    cap_reg;
    logic [CW-1:0] eff_cap;
    op_t           op_reg, op_next;
    logic [TYPE_BITS-1:0]    typ_reg, typ_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic          hit_reg, hit_next, rdv_reg, rdv_next;
    logic          ok_reg, ok_next;
    logic [OutTypeBits-1:0]    ot_reg, ot_next;
    logic [OutPayloadBits-1:0] opay_reg, opay_next;

    logic [2:0] in_op;
    logic [TYPE_BITS-1:0] in_type;
    logic [PAYLOAD_BITS-1:0] in_pay;
    logic [TYPE_BITS-1:0] rd_type;
    logic [CountBits-1:0] fc;

    assign in_op   = s_tdata[2:0];
    assign in_type = s_tdata[3 +: TYPE_BITS];
    assign in_pay  = s_tdata[3+TYPE_BITS +: PAYLOAD_BITS];
    assign rd_type = mem_rd[PAYLOAD_BITS +: TYPE_BITS];

    // clamp capacity to [1, DEPTH]
    always_comb begin
        if (cap_reg == 5'd0) begin
            eff_cap = CW'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = CW'(cap_reg);
        end
    end

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] i);
        wrap = (32'(i) + 1 >= DEPTH) ? '0 : AW'(32'(i) + 1);
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESULT);
    assign fc       = CountBits'(cnt_reg);
    assign m_tdata  = {fc == CountBits'(eff_cap), cnt_reg == '0, fc, opay_reg, ot_reg, ok_reg};

    always_comb begin
        state_next = state_reg;
        head_next = head_reg; tail_next = tail_reg; cnt_next = cnt_reg;
        rd_next = rd_reg; wr_next = wr_reg; left_next = left_reg; kept_next = kept_reg;
        op_next = op_reg; typ_next = typ_reg; pay_next = pay_reg;
        hit_next = hit_reg; rdv_next = 1'b0;
        ok_next = ok_reg; ot_next = ot_reg; opay_next = opay_reg;
        mem_we = 1'b0; mem_wa = tail_reg; mem_wd = {typ_reg, pay_reg};
        mem_ra = rd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mem_ra = head_reg;
                if (s_tvalid) begin
                    op_next = op_t'(in_op); typ_next = in_type; pay_next = in_pay;
                    ok_next = 1'b0; ot_next = '0; opay_next = '0;
                    state_next = ST_RESULT;
                    case (op_t'(in_op)) inside
                        OP_PUSH: begin
                            if (cnt_reg < eff_cap) begin
                                mem_we = 1'b1; mem_wa = tail_reg;
                                mem_wd = {in_type, in_pay};
                                tail_next = wrap(tail_reg);
                                cnt_next = cnt_reg + 1'b1; ok_next = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (cnt_reg != '0) begin
                                state_next = ST_POPRD;
                            end
                        end
                        OP_DROP: begin
                            if (cnt_reg != '0) begin
                                head_next = wrap(head_reg);
                                cnt_next = cnt_reg - 1'b1; ok_next = 1'b1;
                            end
                        end
                        OP_UPUSH, OP_PURGE: begin
                            if (op_t'(in_op) == OP_UPUSH && cnt_reg >= eff_cap) begin
                                state_next = ST_RESULT;
                            end else begin
                                rd_next = head_reg; wr_next = head_reg;
                                left_next = cnt_reg; kept_next = '0;
                                hit_next = 1'b0; state_next = ST_SCAN;
                            end
                        end
                        OP_FLUSH: begin
                            head_next = '0; tail_next = '0; cnt_next = '0; ok_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POPRD: begin
                ot_next = OutTypeBits'(rd_type);
                opay_next = OutPayloadBits'(mem_rd[PAYLOAD_BITS-1:0]);
                head_next = wrap(head_reg);
                cnt_next = cnt_reg - 1'b1; ok_next = 1'b1;
                state_next = ST_RESULT;
            end
            ST_SCAN: begin
                // rd issues a read each cycle; rdv marks data for the entry before
                mem_ra = rd_reg;
                if (rdv_reg) begin
                    if (op_reg == OP_PURGE) begin
                        if (rd_type != typ_reg) begin
                            mem_we = 1'b1; mem_wa = wr_reg; mem_wd = mem_rd;
                            wr_next = wrap(wr_reg); kept_next = kept_reg + 1'b1;
                        end
                    end else if (rd_type == typ_reg) begin
                        hit_next = 1'b1;
                    end
                end
                if (left_reg != '0) begin
                    rd_next = wrap(rd_reg); left_next = left_reg - 1'b1; rdv_next = 1'b1;
                end else if (!rdv_reg) begin
                    state_next = ST_RESULT;
                    if (op_reg == OP_PURGE) begin
                        tail_next = wr_reg; cnt_next = kept_reg; ok_next = 1'b1;
                    end else if (!hit_reg) begin
                        mem_we = 1'b1; mem_wa = tail_reg; mem_wd = {typ_reg, pay_reg};
                        tail_next = wrap(tail_reg);
                        cnt_next = cnt_reg + 1'b1; ok_next = 1'b1;
                    end
                end else begin
                    rdv_next = 1'b0;
                end
            end
            ST_RESULT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // a purge write goes behind the read pointer, so reads never see stale data
        if (cfg_we) begin
            head_next = '0; tail_next = '0; cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg <= '0; tail_reg <= '0; cnt_reg <= '0;
            cap_reg <= 5'd16; rdv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next; tail_reg <= tail_next; cnt_reg <= cnt_next;
            rdv_reg <= rdv_next;
            if (cfg_we) cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= rd_next; wr_reg <= wr_next; left_reg <= left_next;
        kept_reg <= kept_next; op_reg <= op_next; typ_reg <= typ_next;
        pay_reg <= pay_next; hit_reg <= hit_next; ok_reg <= ok_next;
        ot_reg <= ot_next; opay_reg <= opay_next;
    end

`include "typed_fifo_with_unique_push_and_purge_defines.svh"

    `TF_ASSERT_IMP(a_cnt_le_cap, aclk, aresetn, 1'b1, cnt_reg <= eff_cap, "count above capacity")
    `TF_ASSERT_IMP(a_rdy_xor_vld, aclk, aresetn, 1'b1, !(s_tready && m_tvalid), "ready with result")
    `TF_ASSERT_NXT(a_pop_ok, aclk, aresetn, state_reg == ST_POPRD, m_tvalid && ok_reg, "pop lost")
endmodule
